[hdl/tlem_pkg.sv]
// ----------------------------------------------------------------------------
// tlem_pkg
// Shared types and constants of the TDMA leader election MAC: payload beats,
// cell control bundle and the election chain link.
// ----------------------------------------------------------------------------
`default_nettype none

package tlem_pkg;

    // group size, fixed by the width of the membership fields
    localparam int NODES      = 16;
    localparam int ID_W       = 5;
    localparam int SLOT_F_W   = 6;
    localparam int ELECT_CNT_W = $clog2(NODES + 1);

    // packet kinds that act on the state
    localparam logic [7:0] MSG_ELECTION = 8'd4;
    localparam logic [7:0] MSG_EXCHANGE = 8'd12;

    // aloha draw threshold while electing
    localparam logic [7:0] ALOHA_LIMIT = 8'd128;

    // input beat kinds
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_RX   = 1'b1;

    // node phases
    localparam logic PHASE_ELECTING = 1'b0;
    localparam logic PHASE_TDMA     = 1'b1;

    // beacon kinds
    localparam logic KIND_ELECTION = 1'b0;
    localparam logic KIND_EXCHANGE = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [7:0]          random_byte;
        logic [7:0]          rx_message_id;
        logic [ID_W-1:0]     rx_sender;
        logic [NODES-1:0]    rx_members;
        logic                rx_state;
        logic [SLOT_F_W-1:0] rx_slot;
    } in_item_t;

    typedef struct packed {
        logic                transmit;
        logic                message_kind;
        logic [SLOT_F_W-1:0] slot_time;
        logic                node_phase;
        logic [ID_W-1:0]     leader;
        logic [NODES-1:0]    member_mask;
    } out_item_t;

    // commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic             boot;
        logic             rx_write;
        logic             detect;
        logic             phase;
        logic [ID_W-1:0]  my_id;
        logic [ID_W-1:0]  sender;
        logic [NODES-1:0] rx_members;
        logic             rx_state;
        logic [NODES-1:0] members;
        logic [NODES-1:0] members_new;
    } cell_ctrl_t;

    // election result rippling down the row of cells
    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] id;
    } chain_link_t;

endpackage

`default_nettype wire

[hdl/tlem_cell.sv]
// ----------------------------------------------------------------------------
// tlem_cell
// Per-node slice of the MAC state: membership bit, knowledge mask, peer phase
// and missed-beacon count, plus one registered stage of the election chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tlem_cell
    import tlem_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int MISS_LIMIT = 4
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  cell_ctrl_t       ctrl,
    input  chain_link_t      chain_in,
    output chain_link_t      chain_out,
    output logic             member
);

    localparam int MISS_W = $clog2(MISS_LIMIT + 2);
    localparam logic [ID_W-1:0]   CELL_ID  = ID_W'(INDEX + 1);
    localparam logic [NODES-1:0]  CELL_BIT = NODES'(1) << INDEX;
    localparam logic [MISS_W-1:0] LIMIT    = MISS_W'(MISS_LIMIT);

    logic              member_reg;
    logic [NODES-1:0]  know_reg;
    logic              peer_phase_reg;
    logic [MISS_W-1:0] miss_reg;
    chain_link_t       chain_reg;

    logic              is_own;
    logic              is_sender;
    logic              match;
    logic [MISS_W-1:0] miss_inc;
    logic              drop;

    // decode of the broadcast ids
    assign is_own    = (ctrl.my_id == CELL_ID);
    assign is_sender = (ctrl.sender == CELL_ID);
    assign match     = (know_reg == ctrl.members);

    // failure detector for this node
    assign miss_inc = (member_reg && (peer_phase_reg == ctrl.phase)) ?
                      miss_reg + MISS_W'(1) : miss_reg;
    assign drop     = member_reg && (miss_inc > LIMIT);

    // node state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg     <= (INDEX == 0);
            know_reg       <= (INDEX == 0) ? CELL_BIT : '0;
            peer_phase_reg <= 1'b0;
            miss_reg       <= '0;
        end
        else if (ctrl.boot)
        begin
            member_reg     <= is_own;
            know_reg       <= is_own ? CELL_BIT : '0;
            peer_phase_reg <= 1'b0;
            miss_reg       <= '0;
        end
        else if (ctrl.rx_write)
        begin
            if (is_sender)
            begin
                member_reg     <= 1'b1;
                know_reg       <= ctrl.rx_members;
                peer_phase_reg <= ctrl.rx_state;
                miss_reg       <= '0;
            end
            else if (is_own)
            begin
                know_reg <= ctrl.members_new;
            end
        end
        else if (ctrl.detect)
        begin
            if (drop)
            begin
                member_reg     <= 1'b0;
                peer_phase_reg <= 1'b0;
            end
            if (is_own || drop)
            begin
                miss_reg <= '0;
            end
            else
            begin
                miss_reg <= miss_inc;
            end
        end
    end

    // election chain stage, lower ids overwrite higher ones
    always_ff @(posedge clk)
    begin
        chain_reg.ok <= chain_in.ok & (~member_reg | match);
        chain_reg.id <= (member_reg && match) ? CELL_ID : chain_in.id;
    end

    assign chain_out = chain_reg;
    assign member    = member_reg;

endmodule

`default_nettype wire

[hdl/tdma_leader_election_mac_core.sv]
// ----------------------------------------------------------------------------
// tdma_leader_election_mac_core
// Medium access controller of one radio node: aloha leader election followed
// by TDMA rounds, with missed-beacon failure detection and slot resync.
// ----------------------------------------------------------------------------
// Every input beat gives one result beat, registered at the moment the input
// is accepted; results reflect the state before the beat. A slot tick passes
// through the tick state, which reduces a resynced slot counter that lies
// beyond the round by one compare and subtract per cycle. A packet of an
// unknown kind or from an out-of-range sender is taken without leaving the
// idle state. For an election or exchange packet the core waits while the
// election result ripples through the row of per-node cells one cell per
// cycle. Writing my_id (only while idle) restores the boot state; the slot
// counter is kept.
`default_nettype none

module tdma_leader_election_mac_core
    import tlem_pkg::*;
#(
    parameter int SLOTS_PER_ROUND = 33,
    parameter int MISS_LIMIT      = 4
)
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_stall,
    input  in_item_t        in_data,
    output logic            out_valid,
    input  wire             out_stall,
    output out_item_t       out_data,
    input  wire             cfg_valid,
    output logic            cfg_ready,
    input  wire [ID_W-1:0]  cfg_data
);

    localparam int SLOT_W = ($clog2(SLOTS_PER_ROUND + 1) > SLOT_F_W) ?
                            $clog2(SLOTS_PER_ROUND + 1) : SLOT_F_W;
    localparam logic [SLOT_W-1:0] ROUND   = SLOT_W'(SLOTS_PER_ROUND);
    localparam logic [SLOT_W:0]   ROUND_X = (SLOT_W + 1)'(SLOTS_PER_ROUND);
    localparam logic [ELECT_CNT_W-1:0] ELECT_LAST = ELECT_CNT_W'(NODES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_TICK  = 3'b010,
        ST_ELECT = 3'b100
    } state_t;

    state_t                 state_reg;
    logic [ID_W-1:0]        my_id_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   tx_en_reg;
    logic                   phase_reg;
    logic [ID_W-1:0]        leader_reg;
    logic [SLOT_W-1:0]      red_reg;
    logic [ELECT_CNT_W-1:0] elect_cnt_reg;
    logic [ID_W-1:0]        sender_reg;
    logic [SLOT_F_W-1:0]    rx_slot_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic             in_accept;
    logic             cfg_accept;
    logic             is_tick;
    logic             rx_act;
    logic             own_slot;
    logic             tx;
    logic [NODES-1:0] members;
    logic [NODES-1:0] own_vec;
    logic [NODES-1:0] sender_vec;
    logic             tick_done;
    logic             alone;
    logic             round_start;
    logic [SLOT_W:0]  red_inc;
    logic [SLOT_W:0]  slot_inc;
    logic             elect_done;
    cell_ctrl_t       ctrl;
    chain_link_t      chain [NODES+1];

    // handshakes, a pending id write holds off the input
    assign in_stall   = (state_reg != ST_IDLE) || (out_valid_reg && out_stall) ||
                        cfg_valid;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign cfg_accept = cfg_valid && cfg_ready;

    // input beat decode
    assign is_tick = (in_data.mode == MODE_TICK);
    assign rx_act  = (in_data.mode == MODE_RX) &&
                     ((in_data.rx_message_id == MSG_ELECTION) ||
                      (in_data.rx_message_id == MSG_EXCHANGE)) &&
                     (in_data.rx_sender != '0) &&
                     (in_data.rx_sender <= ID_W'(NODES));

    // one-hot id vectors
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            own_vec[i]    = (my_id_reg == ID_W'(i + 1));
            sender_vec[i] = (in_data.rx_sender == ID_W'(i + 1));
        end
    end

    // beacon decision on the state before the beat
    assign own_slot = (slot_reg == SLOT_W'({my_id_reg, 1'b0}));
    assign tx       = is_tick && tx_en_reg && own_slot &&
                      ((phase_reg == PHASE_TDMA) || (in_data.random_byte < ALOHA_LIMIT));

    // tick completion once the counter copy is inside the round
    assign tick_done   = (state_reg == ST_TICK) && (red_reg < ROUND);
    assign alone       = (members == own_vec);
    assign round_start = (red_reg == '0);
    assign red_inc     = {1'b0, red_reg} + (SLOT_W + 1)'(1);
    assign slot_inc    = {1'b0, slot_reg} + (SLOT_W + 1)'(1);
    assign elect_done  = (state_reg == ST_ELECT) && (elect_cnt_reg == ELECT_LAST);

    // cell commands
    always_comb
    begin
        ctrl.boot        = cfg_accept;
        ctrl.rx_write    = in_accept && rx_act;
        ctrl.detect      = tick_done && tx_en_reg &&
                           (((phase_reg == PHASE_ELECTING) && round_start && !alone) ||
                            ((phase_reg == PHASE_TDMA) && own_slot));
        ctrl.phase       = phase_reg;
        ctrl.my_id       = cfg_accept ? cfg_data : my_id_reg;
        ctrl.sender      = in_data.rx_sender;
        ctrl.rx_members  = in_data.rx_members;
        ctrl.rx_state    = in_data.rx_state;
        ctrl.members     = members;
        ctrl.members_new = members | sender_vec;
    end

    // row of node cells, election chain fed from the top id
    assign chain[NODES] = '{ok: 1'b1, id: '0};

    for (genvar g = 0; g < NODES; g++)
    begin : g_cell
        tlem_cell #(
            .INDEX      (g),
            .MISS_LIMIT (MISS_LIMIT)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .chain_in  (chain[g+1]),
            .chain_out (chain[g]),
            .member    (members[g])
        );
    end

    // sequencer and node-wide state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            my_id_reg     <= ID_W'(1);
            slot_reg      <= '0;
            tx_en_reg     <= 1'b0;
            phase_reg     <= PHASE_ELECTING;
            leader_reg    <= ID_W'(1);
            red_reg       <= '0;
            elect_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_accept)
                    begin
                        my_id_reg  <= cfg_data;
                        tx_en_reg  <= 1'b0;
                        phase_reg  <= PHASE_ELECTING;
                        leader_reg <= cfg_data;
                    end
                    if (in_accept && is_tick)
                    begin
                        red_reg   <= slot_reg;
                        state_reg <= ST_TICK;
                    end
                    else if (in_accept && rx_act)
                    begin
                        elect_cnt_reg <= '0;
                        state_reg     <= ST_ELECT;
                    end
                end
                ST_TICK:
                begin
                    if (!tick_done)
                    begin
                        red_reg <= red_reg - ROUND;
                    end
                    else
                    begin
                        if (tx_en_reg && (phase_reg == PHASE_ELECTING) &&
                            round_start && alone)
                        begin
                            phase_reg  <= PHASE_TDMA;
                            leader_reg <= my_id_reg;
                        end
                        if (slot_inc == ROUND_X)
                        begin
                            tx_en_reg <= 1'b1;
                        end
                        slot_reg  <= (red_inc == ROUND_X) ? '0 : red_inc[SLOT_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ELECT:
                begin
                    if (!elect_done)
                    begin
                        elect_cnt_reg <= elect_cnt_reg + ELECT_CNT_W'(1);
                    end
                    else
                    begin
                        phase_reg  <= chain[0].ok ? PHASE_TDMA : PHASE_ELECTING;
                        leader_reg <= chain[0].ok ? chain[0].id : my_id_reg;
                        if (chain[0].ok && (chain[0].id == sender_reg))
                        begin
                            slot_reg <= SLOT_W'(rx_slot_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // packet fields kept for the end of the election
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sender_reg  <= in_data.rx_sender;
            rx_slot_reg <= in_data.rx_slot;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg.transmit     <= tx;
            out_data_reg.message_kind <= (tx && (phase_reg == PHASE_TDMA)) ?
                                         KIND_EXCHANGE : KIND_ELECTION;
            out_data_reg.slot_time    <= slot_reg[SLOT_F_W-1:0];
            out_data_reg.node_phase   <= phase_reg;
            out_data_reg.leader       <= leader_reg;
            out_data_reg.member_mask  <= members;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the sender always belongs to the group while the election runs
    a_members_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ELECT) |-> (members != '0))
        else $error("empty membership during election");

    // a result beat appears only after an input beat was taken
    a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept))
        else $error("result beat without input beat");

    // slot reduction subtracts one round per cycle
    a_reduce_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_TICK) && (red_reg >= ROUND)) |=>
        ((state_reg == ST_TICK) && (red_reg == $past(red_reg) - ROUND)))
        else $error("slot reduction step wrong");

    // a finished tick leaves the counter inside the round
    a_slot_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        tick_done |=> (slot_reg < ROUND))
        else $error("slot counter beyond round after tick");

    // the election chain count never runs past the row length
    a_elect_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ELECT) |-> (elect_cnt_reg <= ELECT_LAST))
        else $error("election count overrun");

endmodule

`default_nettype wire

[bench/tdma_leader_election_mac_core_test.sv]
// ----------------------------------------------------------------------------
// tdma_leader_election_mac_core_test
// Self-checking bench for the TDMA leader election MAC core. A model of the
// node tracks slot timing, election, membership and missed beacons, and each
// result beat is checked against it field by field. Directed edge cases come
// first, then randomized group traffic under several node ids, output
// backpressure and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdma_leader_election_mac_core_test;
    import tlem_pkg::*;

    localparam int SLOTS_PER_ROUND = 33;
    localparam int MISS_LIMIT      = 4;
    // longest beat is an election packet, plus margin
    localparam int SETTLE_CYCLES   = NODES + 10;
    localparam int HOLD_CYCLES     = 400;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    in_item_t        in_data;
    logic            out_valid;
    logic            out_stall;
    out_item_t       out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [ID_W-1:0] cfg_data;

    // node model state
    logic [ID_W-1:0]  node_id;
    int               slot_ctr;
    bit               tx_enabled;
    logic             node_phase;
    logic [NODES-1:0] member_set;
    logic [ID_W-1:0]  leader_id;
    logic [NODES-1:0] knowledge [NODES];
    logic             peer_phase [NODES];
    int               miss_cnt [NODES];

    // expected result beats, oldest first
    out_item_t status_q[$];

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    bit hold_off = 1'b0;

    int n_beats     = 0;
    int n_ignored   = 0;
    int n_results   = 0;
    int n_beacons   = 0;
    int n_resyncs   = 0;
    int n_drops     = 0;
    int n_ids       = 0;
    int n_errors    = 0;
    int n_mismatch  = 0;

    tdma_leader_election_mac_core #(
        .SLOTS_PER_ROUND (SLOTS_PER_ROUND),
        .MISS_LIMIT      (MISS_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // node model
    // ------------------------------------------------------------------------

    function automatic bit id_assigned();
        return node_id >= 1 && node_id <= NODES;
    endfunction

    function automatic logic [NODES-1:0] own_bit();
        return id_assigned() ? (NODES'(1) << (node_id - 1)) : '0;
    endfunction

    // boot values, applied on reset and on every id write
    function automatic void boot_node();
        tx_enabled = 1'b0;
        node_phase = PHASE_ELECTING;
        member_set = own_bit();
        leader_id  = node_id;
        for (int i = 0; i < NODES; i++)
        begin
            knowledge[i]  = '0;
            peer_phase[i] = 1'b0;
            miss_cnt[i]   = 0;
        end
        if (id_assigned())
            knowledge[node_id - 1] = own_bit();
    endfunction

    // missed-beacon detector
    function automatic void count_missed_beacons();
        for (int i = 0; i < NODES; i++)
        begin
            if (member_set[i])
            begin
                if (peer_phase[i] == node_phase)
                    miss_cnt[i]++;
                if (miss_cnt[i] > MISS_LIMIT)
                begin
                    member_set[i] = 1'b0;
                    miss_cnt[i]   = 0;
                    peer_phase[i] = 1'b0;
                    n_drops++;
                end
            end
        end
        if (id_assigned())
            miss_cnt[node_id - 1] = 0;
    endfunction

    // lowest agreeing member leads once every member agrees
    function automatic void elect_leader();
        int members_seen;
        int agreeing;
        members_seen = 0;
        agreeing     = 0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (member_set[i])
            begin
                if (knowledge[i] == member_set)
                begin
                    agreeing++;
                    leader_id = ID_W'(i + 1);
                end
                members_seen++;
            end
        end
        if (members_seen == agreeing)
            node_phase = PHASE_TDMA;
        else
        begin
            leader_id  = node_id;
            node_phase = PHASE_ELECTING;
        end
    endfunction

    // status beat for one input beat, advancing the model
    function automatic out_item_t predict_status(in_item_t b);
        out_item_t r;
        bit        own_slot;
        int        s;
        r.transmit     = 1'b0;
        r.message_kind = KIND_ELECTION;
        r.slot_time    = SLOT_F_W'(slot_ctr);
        r.node_phase   = node_phase;
        r.leader       = leader_id;
        r.member_mask  = member_set;
        if (b.mode == MODE_TICK)
        begin
            own_slot = slot_ctr == 2 * int'(node_id);
            if (tx_enabled)
            begin
                if (node_phase == PHASE_ELECTING)
                begin
                    if (b.random_byte < ALOHA_LIMIT && own_slot)
                        r.transmit = 1'b1;
                    if (slot_ctr % SLOTS_PER_ROUND == 0)
                    begin
                        if (member_set == own_bit())
                        begin
                            node_phase = PHASE_TDMA;
                            leader_id  = node_id;
                        end
                        else
                            count_missed_beacons();
                    end
                end
                else if (own_slot)
                begin
                    r.transmit     = 1'b1;
                    r.message_kind = KIND_EXCHANGE;
                    count_missed_beacons();
                end
            end
            slot_ctr++;
            if (slot_ctr == SLOTS_PER_ROUND)
                tx_enabled = 1'b1;
            slot_ctr = slot_ctr % SLOTS_PER_ROUND;
        end
        else if ((b.rx_message_id == MSG_ELECTION || b.rx_message_id == MSG_EXCHANGE)
                 && b.rx_sender >= 1 && b.rx_sender <= NODES)
        begin
            s = int'(b.rx_sender) - 1;
            member_set[s] = 1'b1;
            if (id_assigned())
                knowledge[node_id - 1] = member_set;
            knowledge[s]  = b.rx_members;
            miss_cnt[s]   = 0;
            peer_phase[s] = b.rx_state;
            elect_leader();
            if (leader_id == b.rx_sender && node_phase == PHASE_TDMA)
            begin
                slot_ctr = int'(b.rx_slot);
                n_resyncs++;
            end
        end
        else
            n_ignored++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // beat helpers
    // ------------------------------------------------------------------------

    function automatic in_item_t random_beat();
        in_item_t b;
        b.mode          = MODE_TICK;
        b.random_byte   = 8'($urandom_range(0, 255));
        b.rx_message_id = 8'($urandom_range(0, 255));
        b.rx_sender     = ID_W'($urandom_range(0, 31));
        b.rx_members    = NODES'($urandom_range(0, 65535));
        b.rx_state      = 1'($urandom_range(0, 1));
        b.rx_slot       = SLOT_F_W'($urandom_range(0, 63));
        return b;
    endfunction

    function automatic in_item_t tick_beat(logic [7:0] draw);
        in_item_t b;
        b             = random_beat();
        b.mode        = MODE_TICK;
        b.random_byte = draw;
        return b;
    endfunction

    function automatic in_item_t rx_beat(logic [7:0] msg, logic [ID_W-1:0] sender,
                                         logic [NODES-1:0] mask, logic state,
                                         logic [SLOT_F_W-1:0] slot);
        in_item_t b;
        b               = random_beat();
        b.mode          = MODE_RX;
        b.rx_message_id = msg;
        b.rx_sender     = sender;
        b.rx_members    = mask;
        b.rx_state      = state;
        b.rx_slot       = slot;
        return b;
    endfunction

    // offer one beat, wait for it to be taken, then record its status
    task automatic send_beat(input in_item_t b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        status_q.push_back(predict_status(b));
        n_beats++;
    endtask

    // stop offering and let every expected beat come out
    task automatic drain();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_my_id(input logic [ID_W-1:0] id);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_id = id;
        boot_node();
        n_ids++;
    endtask

    // group traffic: ticks, beacons from a changing peer group, some noise
    task automatic run_traffic(input int n_items);
        logic [NODES-1:0]    group_mask;
        logic [NODES-1:0]    mask;
        logic [ID_W-1:0]     sender;
        logic [SLOT_F_W-1:0] slot;
        logic                state;
        int                  pick;
        group_mask = '0;
        for (int k = 0; k < n_items; k++)
        begin
            // regroup now and then so stale members get dropped
            if (group_mask == '0 || $urandom_range(0, 199) == 0)
            begin
                group_mask = own_bit();
                repeat ($urandom_range(1, 4))
                    group_mask[$urandom_range(0, NODES - 1)] = 1'b1;
                if (group_mask == own_bit())
                    group_mask[(int'(node_id) % NODES)] = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_beat(tick_beat(8'($urandom_range(0, 255))));
            else if (pick < 88)
            begin
                do
                    sender = ID_W'($urandom_range(1, NODES));
                while (!group_mask[sender - 1]);
                mask = ($urandom_range(0, 6) == 0) ? NODES'($urandom_range(0, 65535))
                                                  : group_mask;
                state = ($urandom_range(0, 3) != 0) ? node_phase
                                                    : 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    slot = SLOT_F_W'($urandom_range(SLOTS_PER_ROUND, 63));
                else if (pick < 6)
                    slot = SLOT_F_W'($urandom_range(0, SLOTS_PER_ROUND - 1));
                else
                    slot = SLOT_F_W'(slot_ctr);
                send_beat(rx_beat(($urandom_range(0, 1) != 0) ? MSG_EXCHANGE
                                                               : MSG_ELECTION,
                                  sender, mask, state, slot));
            end
            else if (pick < 95)
            begin
                // packet of arbitrary kind and sender
                send_beat(rx_beat(8'($urandom_range(0, 255)),
                                  ID_W'($urandom_range(0, 31)),
                                  NODES'($urandom_range(0, 65535)),
                                  1'($urandom_range(0, 1)),
                                  SLOT_F_W'($urandom_range(0, 63))));
            end
            else
            begin
                // valid kind from a sender outside the group range
                sender = ($urandom_range(0, 2) == 0) ? '0
                                                     : ID_W'($urandom_range(NODES + 1, 31));
                send_beat(rx_beat(MSG_ELECTION, sender, NODES'($urandom_range(0, 65535)),
                                  1'($urandom_range(0, 1)),
                                  SLOT_F_W'($urandom_range(0, 63))));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, both packet kinds, ignored packets, resync past the round
    task automatic test_field_extremes();
        write_my_id(ID_W'(1));
        send_beat(tick_beat(8'd0));
        send_beat(tick_beat(8'd127));
        send_beat(tick_beat(ALOHA_LIMIT));
        send_beat(tick_beat(8'd255));
        send_beat(rx_beat(MSG_ELECTION, ID_W'(2), 16'h0003, PHASE_ELECTING, 6'd0));
        send_beat(rx_beat(MSG_EXCHANGE, ID_W'(1), 16'h0003, PHASE_TDMA, 6'd32));
        send_beat(tick_beat(8'd0));
        send_beat(tick_beat(8'd255));
        send_beat(rx_beat(MSG_ELECTION, ID_W'(16), 16'hFFFF, PHASE_TDMA, 6'd5));
        send_beat(rx_beat(MSG_EXCHANGE, ID_W'(16), 16'h8003, PHASE_TDMA, 6'd7));
        send_beat(rx_beat(MSG_ELECTION, ID_W'(2), 16'h8003, PHASE_TDMA, 6'd9));
        send_beat(rx_beat(MSG_EXCHANGE, ID_W'(1), 16'h8003, PHASE_TDMA, 6'd63));
        send_beat(tick_beat(8'd1));
        send_beat(rx_beat(MSG_EXCHANGE, ID_W'(1), 16'h0000, PHASE_ELECTING, 6'd33));
        send_beat(rx_beat(8'd0, ID_W'(5), 16'hFFFF, PHASE_TDMA, 6'd63));
        send_beat(rx_beat(8'd255, ID_W'(5), 16'h0000, PHASE_ELECTING, 6'd0));
        send_beat(rx_beat(8'd3, ID_W'(3), 16'h0004, PHASE_TDMA, 6'd1));
        send_beat(rx_beat(8'd13, ID_W'(3), 16'h0004, PHASE_TDMA, 6'd1));
        send_beat(rx_beat(MSG_ELECTION, ID_W'(0), 16'hFFFF, PHASE_TDMA, 6'd2));
        send_beat(rx_beat(MSG_EXCHANGE, ID_W'(17), 16'hFFFF, PHASE_TDMA, 6'd2));
        send_beat(rx_beat(MSG_ELECTION, ID_W'(31), 16'hFFFF, PHASE_TDMA, 6'd2));
        send_beat(tick_beat(8'd128));
    endtask

    task automatic test_election_top_id();
        write_my_id(ID_W'(NODES));
        run_traffic(480);
    endtask

    task automatic test_election_base_id();
        write_my_id(ID_W'(1));
        run_traffic(380);
    endtask

    task automatic test_election_mid_id();
        write_my_id(ID_W'($urandom_range(2, NODES - 1)));
        run_traffic(380);
    endtask

    // ids with no membership bit and no table entry
    task automatic test_unassigned_id();
        write_my_id(ID_W'(0));
        run_traffic(60);
        write_my_id(ID_W'(31));
        run_traffic(60);
    endtask

    // long receiver hold-off while beats keep coming
    task automatic test_output_backpressure();
        write_my_id(ID_W'($urandom_range(1, NODES)));
        hold_req = 1'b1;
        run_traffic(150);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_my_id(ID_W'($urandom_range(1, NODES)));
        run_traffic(300);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        node_id   = ID_W'(1);
        slot_ctr  = 0;
        boot_node();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_election_top_id();
        test_election_base_id();
        test_election_mid_id();
        test_unassigned_id();
        test_output_backpressure();
        test_steady_stream();
        drain();

        $display("covered %0d input beats (%0d ignored packets) over %0d id settings",
                 n_beats, n_ignored, n_ids);
        $display("%0d results checked, %0d beacons, %0d slot resyncs, %0d members dropped",
                 n_results, n_beacons, n_resyncs, n_drops);
        if (n_errors == 0 && status_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall bursts, long hold-off on request
    initial
    begin
        int burst;
        burst     = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // hold-off length counted here
    initial
    begin
        forever
        begin
            wait (hold_req);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off = 1'b0;
            hold_req = 1'b0;
        end
    end

    // result check against the oldest expected beat
    initial
    begin
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                n_results++;
                if (out_data.transmit)
                    n_beacons++;
                if (status_q.size() == 0)
                begin
                    n_errors++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result beat at %0t: %p", $time, out_data);
                end
                else
                begin
                    want = status_q.pop_front();
                    if (out_data.transmit     !== want.transmit     ||
                        out_data.message_kind !== want.message_kind ||
                        out_data.slot_time    !== want.slot_time    ||
                        out_data.node_phase   !== want.node_phase   ||
                        out_data.leader       !== want.leader       ||
                        out_data.member_mask  !== want.member_mask)
                    begin
                        n_errors++;
                        n_mismatch++;
                        if (n_mismatch <= 10)
                        begin
                            $display("mismatch at %0t, result %0d", $time, n_results);
                            $display("  expected tx=%0d kind=%0d slot=%0d phase=%0d ldr=%0d mem=%h",
                                     want.transmit, want.message_kind, want.slot_time,
                                     want.node_phase, want.leader, want.member_mask);
                            $display("  actual   tx=%0d kind=%0d slot=%0d phase=%0d ldr=%0d mem=%h",
                                     out_data.transmit, out_data.message_kind,
                                     out_data.slot_time, out_data.node_phase,
                                     out_data.leader, out_data.member_mask);
                        end
                    end
                end
            end
        end
    end

    // run limit: ~2000 beats, plus hold-off and config pauses, taken several
    // times over
    initial
    begin
        #(5_000_000);
        $display("timeout with %0d results still expected", status_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
